// ===== hw/rtl/i128alu_pkg.sv =====
// package with opcodes, widths and shared types for the 128-bit alu
`default_nettype none
package i128alu_pkg;
	localparam int WordBits = 128;
	localparam int CntBits = 8;
	localparam int IterBits = 7;
	localparam int QueueDepth = 2;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_AND = 4'd4, OP_OR = 4'd5, OP_XOR = 4'd6, OP_NOT = 4'd7,
		OP_SHL = 4'd8, OP_SAR = 4'd9, OP_ROL = 4'd10, OP_ROR = 4'd11,
		OP_CMP = 4'd12
	} op_t;

	typedef struct packed {
		logic [WordBits-1:0] a;
		logic [WordBits-1:0] b;
		logic [3:0] op;
		logic [CntBits-1:0] cnt;
	} in_beat_t;

	typedef struct packed {
		logic [WordBits-1:0] result;
		logic less;
		logic equal;
		logic div_zero;
	} out_beat_t;

	// front classification handed to the back end
	typedef struct packed {
		logic iter;
		logic is_div;
		logic neg_res;
		logic div_zero;
		logic less;
		logic equal;
		logic [WordBits-1:0] x;
		logic [WordBits-1:0] y;
	} work_t;
endpackage
`default_nettype wire

// ===== hw/rtl/i128alu_if.sv =====
// valid/ready channel interface
`default_nettype none
interface i128alu_if #(parameter int W = 1);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/i128alu_front.sv =====
// front end: flags, simple ops, operand prep for mul and div
`default_nettype none
module i128alu_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire i128alu_pkg::in_beat_t in_data,
	output logic wk_valid,
	input  wire logic wk_ready,
	output i128alu_pkg::work_t wk_data
);
	localparam int W = i128alu_pkg::WordBits;
	logic [W-1:0] a, b, abs_a, abs_b, r, rot_l, rot_r;
	logic sa, sb;
	logic [6:0] s;
	i128alu_pkg::work_t w;
	logic valid_q;
	i128alu_pkg::work_t data_q;

	assign a = in_data.a;
	assign b = in_data.b;
	assign sa = a[W-1];
	assign sb = b[W-1];
	assign abs_a = sa ? (~a + 1'b1) : a;
	assign abs_b = sb ? (~b + 1'b1) : b;
	assign s = in_data.cnt[6:0];
	assign rot_l = (a << s) | (a >> (8'd128 - {1'b0, s}));
	assign rot_r = (a >> s) | (a << (8'd128 - {1'b0, s}));

	always_comb begin
		case (in_data.op)
			i128alu_pkg::OP_ADD: r = a + b;
			i128alu_pkg::OP_SUB: r = a - b;
			i128alu_pkg::OP_AND: r = a & b;
			i128alu_pkg::OP_OR:  r = a | b;
			i128alu_pkg::OP_XOR: r = a ^ b;
			i128alu_pkg::OP_NOT: r = ~a;
			i128alu_pkg::OP_SHL: r = in_data.cnt[7] ? '0 : (a << s);
			i128alu_pkg::OP_SAR: r = in_data.cnt[7] ? {W{sa}} : W'($signed(a) >>> s);
			i128alu_pkg::OP_ROL: r = (s == 7'd0) ? a : rot_l;
			i128alu_pkg::OP_ROR: r = (s == 7'd0) ? a : rot_r;
			default: r = '0;
		endcase
		w.less = (sa != sb) ? sa : (a < b);
		w.equal = (a == b);
		w.div_zero = (in_data.op == i128alu_pkg::OP_DIV) && (b == '0);
		w.is_div = (in_data.op == i128alu_pkg::OP_DIV) && (b != '0);
		w.iter = (in_data.op == i128alu_pkg::OP_MUL) || w.is_div;
		w.neg_res = w.is_div && (sa != sb);
		w.x = w.is_div ? abs_a : ((in_data.op == i128alu_pkg::OP_MUL) ? a : r);
		w.y = w.is_div ? abs_b : b;
	end

	assign in_ready = !valid_q || wk_ready;
	assign wk_valid = valid_q;
	assign wk_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= w;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/i128alu_queue.sv =====
// two-entry queue between front and back
`default_nettype none
module i128alu_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	output logic wr_ready,
	input  wire i128alu_pkg::work_t wr_data,
	output logic rd_valid,
	input  wire logic rd_ready,
	output i128alu_pkg::work_t rd_data
);
	i128alu_pkg::work_t mem_q [i128alu_pkg::QueueDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'(i128alu_pkg::QueueDepth);
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(i128alu_pkg::QueueDepth)) else $error("queue count out of range");
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'(i128alu_pkg::QueueDepth)) |-> !wr_ready)
		else $error("full queue took a beat");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_valid && !rd_ready && !$past(rd)) |=> rd_valid) else $error("head lost");
endmodule
`default_nettype wire

// ===== hw/rtl/i128alu_back.sv =====
// back end: iterative shift-add multiply and restoring divide
`default_nettype none
module i128alu_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wk_valid,
	output logic wk_ready,
	input  wire i128alu_pkg::work_t wk_data,
	output logic out_valid,
	input  wire logic out_ready,
	output i128alu_pkg::out_beat_t out_data
);
	localparam int W = i128alu_pkg::WordBits;
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001, ST_RUN = 3'b010, ST_DONE = 3'b100
	} state_t;
	state_t state_q;
	logic [i128alu_pkg::IterBits-1:0] idx_q;
	logic [W-1:0] x_q, y_q, acc_q, rem_q;
	logic is_div_q, neg_q, less_q, equal_q;
	logic [W:0] trial;
	logic [W-1:0] rem_sh;
	logic out_valid_q;
	logic out_load;
	i128alu_pkg::out_beat_t out_q;

	assign rem_sh = {rem_q[W-2:0], x_q[W-1]};
	assign trial = {1'b0, rem_sh} - {1'b0, y_q};
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign wk_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_load = ((state_q == ST_IDLE) && wk_valid && wk_ready && !wk_data.iter)
		|| ((state_q == ST_DONE) && (!out_valid_q || out_ready));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (wk_valid && wk_ready && wk_data.iter) begin
						state_q <= ST_RUN;
						idx_q <= '0;
					end
				end
				ST_RUN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == '1) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (wk_valid && wk_ready) begin
					x_q <= wk_data.x;
					y_q <= wk_data.y;
					acc_q <= '0;
					rem_q <= '0;
					is_div_q <= wk_data.is_div;
					neg_q <= wk_data.neg_res;
					less_q <= wk_data.less;
					equal_q <= wk_data.equal;
					out_q.result <= wk_data.x;
					out_q.less <= wk_data.less;
					out_q.equal <= wk_data.equal;
					out_q.div_zero <= wk_data.div_zero;
				end
			end
			ST_RUN: begin
				if (is_div_q) begin
					x_q <= {x_q[W-2:0], !trial[W]};
					rem_q <= trial[W] ? rem_sh : trial[W-1:0];
				end else begin
					if (y_q[0]) acc_q <= acc_q + x_q;
					x_q <= {x_q[W-2:0], 1'b0};
					y_q <= {1'b0, y_q[W-1:1]};
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_q.result <= is_div_q ? (neg_q ? (~x_q + 1'b1) : x_q) : acc_q;
					out_q.less <= less_q;
					out_q.equal <= equal_q;
					out_q.div_zero <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_run_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !wk_ready) else $error("took work while busy");
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && idx_q == '1) |=> state_q == ST_DONE)
		else $error("iteration count wrong");
endmodule
`default_nettype wire

// ===== hw/rtl/int128_signed_alu.sv =====
// top level of the 128-bit signed alu
// simple ops pass the front register, the queue and the back output register
// mul and div run the shared 128-step loop and block the back end while it runs
// simple ops one beat per cycle unless mul/div or output back-pressure stalls them
// a two-entry queue lets the front take beats while the back iterates, until full
// reset: arst_n clears all valid flags, the queue and the state machine
`default_nettype none
module int128_signed_alu (
	input  wire logic clk,
	input  wire logic arst_n,
	i128alu_if.sink   in_ch,
	i128alu_if.source out_ch
);
	logic fq_valid, fq_ready, qb_valid, qb_ready;
	i128alu_pkg::work_t fq_data, qb_data;
	i128alu_pkg::in_beat_t in_beat;
	i128alu_pkg::out_beat_t out_beat;

	assign in_beat = i128alu_pkg::in_beat_t'(in_ch.data);
	assign out_ch.data = out_beat;

	i128alu_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_beat),
		.wk_valid(fq_valid), .wk_ready(fq_ready), .wk_data(fq_data)
	);

	i128alu_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
		.rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
	);

	i128alu_back u_back (
		.clk(clk), .arst_n(arst_n),
		.wk_valid(qb_valid), .wk_ready(qb_ready), .wk_data(qb_data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_beat)
	);
endmodule
`default_nettype wire
